// ===== rtl/steq_pkg.sv =====
// shared types and constants of the time-ordered event queue
// used by steq_cell and stable_time_ordered_event_queue, no dependencies
package steq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 32;
    localparam int TAG_BITS    = 16;
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam int S_FIELD_BITS = OP_BITS + TIME_BITS + TAG_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = STATUS_BITS + TIME_BITS + TAG_BITS + COUNT_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // contents of one cell as seen by its neighbours
    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] time_key;
        logic [TAG_BITS-1:0]  event_tag;
    } cell_data_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                 probe;      // evaluate flag for the incoming transfer
        op_t                  probe_op;
        logic [TIME_BITS-1:0] probe_time;
        logic [TAG_BITS-1:0]  probe_tag;
        logic                 ins_en;     // commit an insert
        logic                 rem_en;     // commit a pop or delete
        logic [TIME_BITS-1:0] new_time;
        logic [TAG_BITS-1:0]  new_tag;
    } cell_cmd_t;

endpackage

// ===== rtl/steq_cell.sv =====
// one slot of the sorted chain: holds an entry and a registered compare flag
// depends on steq_pkg
module steq_cell
    import steq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  cell_data_t left_data,   // lower neighbour
    input  cell_data_t right_data,  // upper neighbour
    input  logic       sel,         // this cell moves
    input  logic       sel_left,    // lower neighbour moves too
    output cell_data_t data,
    output logic       flag
);

    logic                 valid_reg, valid_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic                 flag_reg, flag_next;

    // insert: every slot holding a later time or empty; delete: tag match; pop: every slot
    always_comb
    begin
        case (cmd.probe_op)
            OP_INSERT: flag_next = !valid_reg || (time_reg > cmd.probe_time);
            OP_DELETE: flag_next = valid_reg && (tag_reg == cmd.probe_tag);
            OP_POP:    flag_next = 1'b1;
            default:   flag_next = 1'b0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        time_next  = time_reg;
        tag_next   = tag_reg;
        if (cmd.ins_en && sel)
        begin
            if (sel_left)
            begin
                valid_next = left_data.valid;
                time_next  = left_data.time_key;
                tag_next   = left_data.event_tag;
            end
            else
            begin
                valid_next = 1'b1;
                time_next  = cmd.new_time;
                tag_next   = cmd.new_tag;
            end
        end
        else if (cmd.rem_en && sel)
        begin
            valid_next = right_data.valid;
            time_next  = right_data.time_key;
            tag_next   = right_data.event_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.probe)
            begin
                flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        tag_reg  <= tag_next;
    end

    assign data.valid     = valid_reg;
    assign data.time_key  = time_reg;
    assign data.event_tag = tag_reg;
    assign flag           = flag_reg;

endmodule

// ===== rtl/stable_time_ordered_event_queue.sv =====
// top level of the time-ordered event queue: a chain of steq_cell slots
// plus the operation sequencer and result register; depends on steq_pkg
//
// a result is offered from the result register after the shift phase, later while an earlier one waits
// no new operation is taken until the shift phase of the last one commits; that phase waits for a free result register
// reset: rst_n clears all slot valid bits, the entry count and the result valid bit
module stable_time_ordered_event_queue
    import steq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,  // op, time_key, event_tag, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata   // status, out_time, out_tag, entry_count, zero pad
);

    // unpacked input fields
    op_t                  in_op;
    logic [TIME_BITS-1:0] in_time;
    logic [TAG_BITS-1:0]  in_tag;

    assign in_op   = op_t'(s_tdata[OP_BITS-1:0]);
    assign in_time = s_tdata[OP_BITS +: TIME_BITS];
    assign in_tag  = s_tdata[OP_BITS+TIME_BITS +: TAG_BITS];

    // sequencer
    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [TIME_BITS-1:0]  out_time_reg, out_time_next;
    logic [TAG_BITS-1:0]   out_tag_reg, out_tag_next;
    logic [COUNT_BITS-1:0] out_count_reg;

    // chain
    cell_cmd_t                    cmd;
    cell_data_t                   cell_q [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]       flags;
    logic [QUEUE_DEPTH-1:0]       sel;
    logic [QUEUE_DEPTH-1:0]       flags_dec;
    logic [QUEUE_DEPTH-1:0]       first_hit;
    logic                         accept;
    logic                         commit;
    logic                         is_full;
    logic                         is_empty;
    logic                         found;
    logic                         ins_ok;
    logic                         rem_ok;
    cell_data_t                   edge_empty;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign is_full  = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // first matching slot of a delete: isolate the lowest set flag with one subtract
    assign flags_dec = flags - QUEUE_DEPTH'(1);
    assign first_hit = flags & ~flags_dec;
    assign found     = |flags;

    // slots that move: insert flags are already monotone (position and above);
    // delete moves the matching slot and everything above it; pop moves all
    always_comb
    begin
        case (op_reg)
            OP_INSERT: sel = flags;
            OP_DELETE: sel = ~(flags ^ flags_dec) | first_hit;
            OP_POP:    sel = '1;
            default:   sel = '0;
        endcase
    end

    // the shift phase commits only when the result register can take the result
    assign commit = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);
    assign ins_ok = (op_reg == OP_INSERT) && !is_full;
    assign rem_ok = ((op_reg == OP_POP) && !is_empty) || ((op_reg == OP_DELETE) && found);

    always_comb
    begin
        cmd.probe      = accept;
        cmd.probe_op   = in_op;
        cmd.probe_time = in_time;
        cmd.probe_tag  = in_tag;
        cmd.ins_en     = commit && ins_ok;
        cmd.rem_en     = commit && rem_ok;
        cmd.new_time   = time_reg;
        cmd.new_tag    = tag_reg;
    end

    // an empty entry beyond either end of the chain
    assign edge_empty = '{valid: 1'b0, time_key: '0, event_tag: '0};

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            cell_data_t left_d;
            cell_data_t right_d;
            logic       sel_l;

            if (gi == 0)
            begin : g_first
                assign left_d = edge_empty;
                assign sel_l  = 1'b0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[gi-1];
                assign sel_l  = sel[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_d = edge_empty;
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end

            steq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_data  (left_d),
                .right_data (right_d),
                .sel        (sel[gi]),
                .sel_left   (sel_l),
                .data       (cell_q[gi]),
                .flag       (flags[gi])
            );
        end
    endgenerate

    // next state, count and result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_time_next   = out_time_reg;
        out_tag_next    = out_tag_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_time_next   = '0;
                    out_tag_next    = '0;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + COUNT_BITS'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_time_next = cell_q[0].time_key;
                                out_tag_next  = cell_q[0].event_tag;
                                count_next    = count_reg - COUNT_BITS'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (found)
                            begin
                                count_next = count_reg - COUNT_BITS'(1);
                            end
                            else
                            begin
                                out_status_next = ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // operands held for the shift phase, result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            time_reg <= in_time;
            tag_reg  <= in_tag;
        end
        out_status_reg <= out_status_next;
        out_time_reg   <= out_time_next;
        out_tag_reg    <= out_tag_next;
        if (commit)
        begin
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_BITS - M_FIELD_BITS){1'b0}},
                       out_count_reg, out_tag_reg, out_time_reg, out_status_reg};

endmodule
